@@ hw/rtl/sfe_pkg.sv @@
// Shared types, constants and a helper function of the sprite framebuffer engine.
package sfe_pkg;

    // Default frame size in pixels
    localparam int SFE_MAX_COLS = 128;
    localparam int SFE_MAX_ROWS = 64;

    // Sprite row widths in pixels
    localparam int SPR_W_WIDE   = 16;
    localparam int SPR_W_NARROW = 8;

    // Stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_WRAP_X = 1'b0;
    localparam logic REG_WRAP_Y = 1'b1;

    // Operation codes carried in tuser
    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_DRAW      = 3'd1,
        OP_SCR_DOWN  = 3'd2,
        OP_SCR_RIGHT = 3'd3,
        OP_SCR_LEFT  = 3'd4,
        OP_LOW_RES   = 3'd5,
        OP_HIGH_RES  = 3'd6,
        OP_READ      = 3'd7
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR
    } t_state;

    // Edge handling settings
    typedef struct packed {
        logic wrap_x;
        logic wrap_y;
    } t_cfg;

    // Remainder of an 8-bit value by a modulus of at least 16: four
    // restoring subtract steps, enough for quotients up to 15.
    function automatic logic [7:0] f_mod8(input logic [7:0] v, input logic [8:0] m);
        logic [11:0] rem;
        logic [11:0] sub;
        rem = {4'b0000, v};
        for (int k = 3; k >= 0; k--) begin
            sub = {3'b000, m} << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[7:0];
    endfunction

endpackage

@@ hw/rtl/sfe_regs.sv @@
// Configuration registers of the sprite framebuffer engine behind an APB-style port.
module sfe_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output sfe_pkg::t_cfg                  o_cfg
);
    import sfe_pkg::*;

    logic r_wrap_x;
    logic r_wrap_y;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready;

    // Register writes; only the word address bit selects the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_x <= 1'b0;
            r_wrap_y <= 1'b0;
        end else if (wr_hit) begin
            if (paddr[2] == REG_WRAP_X) begin
                r_wrap_x <= pwdata[0];
            end else begin
                r_wrap_y <= pwdata[0];
            end
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WRAP_X) begin
            prdata[0] = r_wrap_x;
        end else begin
            prdata[0] = r_wrap_y;
        end
    end

    assign o_cfg.wrap_x = r_wrap_x;
    assign o_cfg.wrap_y = r_wrap_y;

endmodule

@@ hw/rtl/sfe_frame_mem.sv @@
// Frame row memory with one read and one write port and per-row valid bits.
module sfe_frame_mem #(
    parameter int MAX_COLS = sfe_pkg::SFE_MAX_COLS,
    parameter int MAX_ROWS = sfe_pkg::SFE_MAX_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(MAX_ROWS)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(MAX_ROWS)-1:0] i_wr_addr,
    input  logic [MAX_COLS-1:0]         i_wr_data,
    input  logic                        i_clr_upper,
    output logic [MAX_COLS-1:0]         o_rd_data
);
    import sfe_pkg::*;

    localparam int HALF  = MAX_ROWS / 2;

    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_valid;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_valid;

    // Storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Row valid bits: a row never written since reset, or an upper row not
    // written since a resolution switch, reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clr_upper) begin
                r_valid[MAX_ROWS-1:HALF] <= '0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

    // Read and write phases of the sequencer never share a cycle
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && i_wr_en))
        else $error("frame memory read and write in the same cycle");

    // A resolution switch does not write rows in the same cycle
    a_clr_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_upper |-> !i_wr_en)
        else $error("upper-row clear together with a row write");

    // After a resolution switch the upper rows read as empty
    a_upper_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_upper |=> (r_valid[MAX_ROWS-1:HALF] == '0))
        else $error("upper rows still valid after resolution switch");

    // Addresses stay inside the array
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en |-> (32'(i_rd_addr) < MAX_ROWS)) and (i_wr_en |-> (32'(i_wr_addr) < MAX_ROWS)))
        else $error("frame memory address out of range");

endmodule

@@ hw/rtl/sfe_draw_mask.sv @@
// Turns one sprite row into a full-width XOR mask, applying horizontal edge handling.
module sfe_draw_mask #(
    parameter int MAX_COLS = sfe_pkg::SFE_MAX_COLS
) (
    input  logic                [7:0] i_pos_x,
    input  logic               [15:0] i_row_bits,
    input  logic                      i_wide,
    input  logic                      i_wrap_x,
    input  logic                      i_hires,
    output logic       [MAX_COLS-1:0] o_mask
);
    import sfe_pkg::*;

    localparam int          COL_W   = $clog2(MAX_COLS);
    localparam logic [8:0]  COLS_HI = 9'(MAX_COLS);
    localparam logic [8:0]  COLS_LO = 9'(MAX_COLS / 2);

    logic [8:0]  cur_cols;
    logic [7:0]  x_base;
    logic [15:0] pattern;

    assign cur_cols = i_hires ? COLS_HI : COLS_LO;
    // Left edge already folded into the visible width
    assign x_base   = f_mod8(i_pos_x, cur_cols);
    // Narrow rows move up so the leftmost pixel is always bit 15
    assign pattern  = i_wide ? i_row_bits : {i_row_bits[SPR_W_NARROW-1:0], 8'h00};

    // One lane per sprite pixel; lanes are independent
    always_comb begin
        logic [8:0] raw_col;
        logic [8:0] wrap_col;
        o_mask = '0;
        for (int i = 0; i < SPR_W_WIDE; i++) begin
            raw_col  = {1'b0, i_pos_x} + 9'(i);
            wrap_col = {1'b0, x_base} + 9'(i);
            if (wrap_col >= cur_cols) begin
                wrap_col = wrap_col - cur_cols;
            end
            if (pattern[SPR_W_WIDE-1-i] && ((raw_col < cur_cols) || i_wrap_x)) begin
                o_mask[wrap_col[COL_W-1:0]] = 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/sprite_framebuffer_engine_unit.sv @@
// Top level of the sprite framebuffer engine: sequencer, item registers and result stage.
//
// A one-bit frame of MAX_COLS x MAX_ROWS pixels (half of each in low resolution) is
// held one pixel row per memory word. Draw row, read pixel and the resolution switches
// each take a memory read state and a write state, and the next item is taken in the
// write state, so a stream of sprite rows takes each new row while the previous one
// writes back. Clear and the three scrolls sweep the visible rows bottom to top with a
// read and a write per row. Reset needs no clearing pass: per-row valid bits make
// unwritten rows read as empty. Results stay in an output register, so a stalled result
// only holds up the item after it in its final write state.
module sprite_framebuffer_engine_unit #(
    parameter int MAX_COLS = sfe_pkg::SFE_MAX_COLS,
    parameter int MAX_ROWS = sfe_pkg::SFE_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item in
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // pos_x[7:0], pos_y[15:8], row_bits[31:16], wide[32], amount[36:33], zero[39:37]
    input  logic [sfe_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // operation[2:0]
    input  logic [sfe_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // last_row
    input  logic                           i_s_axis_tlast,
    // result out
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // collision[0], pixel[1], zero[7:2]
    output logic [sfe_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import sfe_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam logic [RCNT_W-1:0] ROWS_HI = RCNT_W'(MAX_ROWS);
    localparam logic [RCNT_W-1:0] ROWS_LO = RCNT_W'(MAX_ROWS / 2);
    localparam logic [8:0]        COLS_HI = 9'(MAX_COLS);
    localparam logic [8:0]        COLS_LO = 9'(MAX_COLS / 2);

    // configuration
    t_cfg cfg;

    // sequencer
    t_state r_state, n_state;
    logic   in_ready;
    logic   out_free;
    logic   wr_go;
    logic   step_last;
    logic   sweep_op;
    logic   accept;

    // item registers
    t_op            r_op;
    logic [7:0]     r_px;
    logic [7:0]     r_py;
    logic [15:0]    r_bits;
    logic           r_wide;
    logic           r_last;
    logic [3:0]     r_amt;

    // per-item working state
    logic [ROW_W-1:0]    r_cnt, n_cnt;
    logic [MAX_COLS-1:0] r_mask;
    logic [ROW_W-1:0]    r_wr_row;
    logic                r_pix_ok;
    logic                r_src_ok;
    logic                r_hires, n_hires;
    logic                r_coll_acc;

    // result stage
    logic r_out_valid;
    logic r_out_coll;
    logic r_out_pix;

    // derived values
    logic [RCNT_W-1:0]   cur_rows;
    logic [RCNT_W-1:0]   next_rows;
    logic [8:0]          cur_cols;
    logic [3:0]          shift_n;
    logic [ROW_W-1:0]    row_mod;
    logic                row_ok;
    logic                src_ok;
    logic [MAX_COLS-1:0] draw_mask;
    logic [MAX_COLS-1:0] vis_mask;
    logic [MAX_COLS-1:0] old_row;
    logic                coll_now;
    logic                pix_now;

    // memory port
    logic                mem_rd_en;
    logic [ROW_W-1:0]    mem_rd_addr;
    logic                mem_wr_en;
    logic [ROW_W-1:0]    mem_wr_addr;
    logic [MAX_COLS-1:0] mem_wr_data;
    logic                mem_clr_upper;

    sfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfe_frame_mem #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (mem_rd_en),
        .i_rd_addr   (mem_rd_addr),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .i_clr_upper (mem_clr_upper),
        .o_rd_data   (old_row)
    );

    sfe_draw_mask #(
        .MAX_COLS (MAX_COLS)
    ) u_mask (
        .i_pos_x    (r_px),
        .i_row_bits (r_bits),
        .i_wide     (r_wide),
        .i_wrap_x   (cfg.wrap_x),
        .i_hires    (r_hires),
        .o_mask     (draw_mask)
    );

    // Current geometry and per-item addressing
    assign cur_rows  = r_hires ? ROWS_HI : ROWS_LO;
    assign next_rows = n_hires ? ROWS_HI : ROWS_LO;
    assign cur_cols  = r_hires ? COLS_HI : COLS_LO;
    assign shift_n   = r_hires ? r_amt : (r_amt >> 1);
    assign row_mod   = ROW_W'(f_mod8(r_py, 9'(cur_rows)));
    assign row_ok    = (r_py < 8'(cur_rows)) || cfg.wrap_y;
    assign src_ok    = r_cnt >= ROW_W'(shift_n);
    assign sweep_op  = (r_op == OP_CLEAR) || (r_op == OP_SCR_DOWN) ||
                       (r_op == OP_SCR_RIGHT) || (r_op == OP_SCR_LEFT);
    assign step_last = !sweep_op || (r_cnt == '0);
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign accept    = i_s_axis_tvalid && in_ready;

    // Visible columns for clear
    always_comb begin
        vis_mask = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            if (r_hires || (c < MAX_COLS / 2)) begin
                vis_mask[c] = 1'b1;
            end
        end
    end

    // Read address for the row this step needs
    always_comb begin
        case (r_op)
            OP_DRAW:     mem_rd_addr = row_mod;
            OP_READ:     mem_rd_addr = r_py[ROW_W-1:0];
            OP_SCR_DOWN: mem_rd_addr = r_cnt - ROW_W'(shift_n);
            default:     mem_rd_addr = r_cnt;
        endcase
    end

    // Result values from the row just read
    assign coll_now = r_coll_acc || (|(old_row & r_mask));
    assign pix_now  = r_pix_ok && old_row[r_px[COL_W-1:0]];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, memory commands and handshake
    always_comb begin
        n_state       = r_state;
        in_ready      = 1'b0;
        wr_go         = 1'b0;
        mem_rd_en     = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_cnt;
        mem_wr_data   = old_row;
        mem_clr_upper = 1'b0;
        n_hires       = r_hires;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                mem_rd_en = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                wr_go = !step_last || out_free;
                if (wr_go) begin
                    case (r_op)
                        OP_CLEAR: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = old_row & ~vis_mask;
                        end
                        OP_DRAW: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = r_wr_row;
                            mem_wr_data = old_row ^ r_mask;
                        end
                        OP_SCR_DOWN: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = r_src_ok ? old_row : '0;
                        end
                        OP_SCR_RIGHT: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = old_row << shift_n;
                        end
                        OP_SCR_LEFT: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = old_row >> shift_n;
                        end
                        OP_LOW_RES: begin
                            mem_clr_upper = 1'b1;
                            n_hires       = 1'b0;
                        end
                        OP_HIGH_RES: begin
                            mem_clr_upper = 1'b1;
                            n_hires       = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (step_last) begin
                        in_ready = 1'b1;
                        n_state  = i_s_axis_tvalid ? S_RD : S_IDLE;
                    end else begin
                        n_state  = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sweep counter: sweeps run from the bottom visible row to row 0
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = ROW_W'(next_rows - RCNT_W'(1));
        end else if (wr_go && !step_last) begin
            n_cnt = r_cnt - ROW_W'(1);
        end
    end

    // Item capture and read-phase registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (accept) begin
            r_op   <= t_op'(i_s_axis_tuser);
            r_px   <= i_s_axis_tdata[7:0];
            r_py   <= i_s_axis_tdata[15:8];
            r_bits <= i_s_axis_tdata[31:16];
            r_wide <= i_s_axis_tdata[32];
            r_amt  <= i_s_axis_tdata[36:33];
            r_last <= i_s_axis_tlast;
        end
        if (r_state == S_RD) begin
            r_mask   <= row_ok ? draw_mask : '0;
            r_wr_row <= row_mod;
            r_pix_ok <= ({1'b0, r_px} < cur_cols) && (r_py < 8'(cur_rows));
            r_src_ok <= src_ok;
        end
    end

    // Mode and sprite collision state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hires    <= 1'b0;
            r_coll_acc <= 1'b0;
        end else begin
            r_hires <= n_hires;
            if (wr_go && (r_op == OP_DRAW)) begin
                r_coll_acc <= r_last ? 1'b0 : coll_now;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_go && step_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (wr_go && step_last) begin
            r_out_coll <= (r_op == OP_DRAW) && coll_now;
            r_out_pix  <= (r_op == OP_READ) && pix_now;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b000000, r_out_pix, r_out_coll};

    // An accepted item always starts with a memory read
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD))
        else $error("accepted item did not enter the read phase");

    // No item is taken while a row read is in flight
    a_no_take_in_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !o_s_axis_tready)
        else $error("item taken during the read phase");

    // A sweep step moves exactly one row on, towards row 0
    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_go && !step_last) |=> ((r_state == S_RD) && (r_cnt == $past(r_cnt) - ROW_W'(1))))
        else $error("sweep counter skipped a row");

endmodule

@@ tb/sprite_framebuffer_engine_unit_test.sv @@
// Self-checking testbench of the sprite framebuffer engine: directed and random item streams.
module sprite_framebuffer_engine_unit_test;
    import sfe_pkg::*;

    localparam int RANDOM_ITEMS  = 1350;
    localparam int SETTLE_CYCLES = 2 * SFE_MAX_ROWS + 8;
    // Worst case per item: a longest send gap, a longest result stall and a full
    // sweep of a read and a write per row; about 1400 items stay under a quarter of this.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HALF_PERIOD   = 2;

    typedef struct {
        t_op         op;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] row_bits;
        logic        wide;
        logic        last_row;
        logic [3:0]  amount;
    } t_fb_item;

    typedef struct packed {
        logic collision;
        logic pixel;
    } t_fb_readout;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // pos_x[7:0], pos_y[15:8], row_bits[31:16], wide[32], amount[36:33], zero[39:37]
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    // operation[2:0]
    logic [S_TUSER_W-1:0]  i_s_axis_tuser;
    logic                  i_s_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // collision[0], pixel[1], zero[7:2]
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the frame and the engine's mode
    logic [SFE_MAX_COLS-1:0] frame_rows [SFE_MAX_ROWS];
    logic                    hires_now   = 1'b0;
    logic                    coll_run    = 1'b0;
    logic                    wrap_x_now  = 1'b0;
    logic                    wrap_y_now  = 1'b0;

    t_fb_readout pending_readouts [$];

    int errors          = 0;
    int items_sent      = 0;
    int results_seen    = 0;
    int collisions_seen = 0;
    int lit_reads       = 0;
    int cycle_count     = 0;
    int src_gap_max     = 12;
    int sink_gap_max    = 12;

    sprite_framebuffer_engine_unit i_dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_readouts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap(input int gap_max);
        return (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    endfunction

    // Applies one item to the shadow frame and returns the readout it causes
    function automatic t_fb_readout fb_apply(input t_fb_item it);
        t_fb_readout r;
        int cols, rows, span, n, px, py;
        r    = '0;
        cols = hires_now ? SFE_MAX_COLS : SFE_MAX_COLS / 2;
        rows = hires_now ? SFE_MAX_ROWS : SFE_MAX_ROWS / 2;
        n    = hires_now ? it.amount : it.amount / 2;
        case (it.op)
            OP_CLEAR: begin
                for (int y = 0; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        frame_rows[y][x] = 1'b0;
            end
            OP_DRAW: begin
                span = it.wide ? SPR_W_WIDE : SPR_W_NARROW;
                py   = it.pos_y;
                if (py >= rows && wrap_y_now) py = py % rows;
                for (int k = 0; k < span; k++) begin
                    px = it.pos_x + k;
                    if (px >= cols && wrap_x_now) px = px % cols;
                    // pixels off the edge without wrapping are dropped
                    if (it.row_bits[span-1-k] && px < cols && py < rows) begin
                        if (frame_rows[py][px]) coll_run = 1'b1;
                        frame_rows[py][px] = ~frame_rows[py][px];
                    end
                end
                r.collision = coll_run;
                if (it.last_row) coll_run = 1'b0;
            end
            OP_SCR_DOWN: begin
                for (int y = rows - 1; y >= 0; y--) begin
                    if (y >= n) frame_rows[y] = frame_rows[y-n];
                    else frame_rows[y] = '0;
                end
            end
            OP_SCR_RIGHT: begin
                for (int y = 0; y < rows; y++) frame_rows[y] = frame_rows[y] << n;
            end
            OP_SCR_LEFT: begin
                for (int y = 0; y < rows; y++) frame_rows[y] = frame_rows[y] >> n;
            end
            OP_LOW_RES, OP_HIGH_RES: begin
                hires_now = (it.op == OP_HIGH_RES);
                for (int y = SFE_MAX_ROWS / 2; y < SFE_MAX_ROWS; y++) frame_rows[y] = '0;
            end
            default: begin
                if (it.pos_x < cols && it.pos_y < rows)
                    r.pixel = frame_rows[it.pos_y][it.pos_x];
            end
        endcase
        return r;
    endfunction

    function automatic t_fb_item make_item(input t_op op, input int x, input int y,
                                           input int bits, input bit wide, input bit last,
                                           input int amt);
        t_fb_item it;
        it.op       = op;
        it.pos_x    = x[7:0];
        it.pos_y    = y[7:0];
        it.row_bits = bits[15:0];
        it.wide     = wide;
        it.last_row = last;
        it.amount   = amt[3:0];
        return it;
    endfunction

    // Sends one item after a random gap; valid stays high when the next follows at once
    task automatic send_item(input t_fb_item it);
        int gap;
        gap = draw_gap(src_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {3'b000, it.amount, it.wide, it.row_bits, it.pos_y, it.pos_x};
        i_s_axis_tuser  = it.op;
        i_s_axis_tlast  = it.last_row;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_readouts.push_back(fb_apply(it));
        items_sent++;
    endtask

    task automatic draw_row(input int x, input int y, input int bits, input bit wide,
                            input bit last);
        send_item(make_item(OP_DRAW, x, y, bits, wide, last, 0));
    endtask

    task automatic read_px(input int x, input int y);
        send_item(make_item(OP_READ, x, y, 0, 1'b0, 1'b0, 0));
    endtask

    task automatic frame_op(input t_op op, input int amt);
        send_item(make_item(op, 0, 0, 0, 1'b0, 1'b0, amt));
    endtask

    // Drops valid and waits until every readout is back and the engine is quiet
    task automatic settle_idle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one edge-mode register while idle, then reads it back
    task automatic set_edge_mode(input logic idx, input logic val);
        settle_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {{(APB_DATA_W-1){1'b0}}, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_WRAP_X) wrap_x_now = val;
        else wrap_y_now = val;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(APB_DATA_W-1){1'b0}}, val}) begin
            $display("%0t: register %0d read back: expected %h, actual %h",
                     $time, idx, {{(APB_DATA_W-1){1'b0}}, val}, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Result side: random stalls before each item
    initial begin : result_sink
        int stall;
        i_m_axis_tready = 1'b0;
        forever begin
            stall = draw_gap(sink_gap_max);
            repeat (stall) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Result check against the oldest pending readout
    always @(posedge i_clk) begin : result_check
        t_fb_readout want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_readouts.size() == 0) begin
                $display("%0t: result with none pending: expected nothing, actual %h",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_readouts.pop_front();
                if (o_m_axis_tdata[0] !== want.collision) begin
                    $display("%0t: collision mismatch: expected %b, actual %b",
                             $time, want.collision, o_m_axis_tdata[0]);
                    errors++;
                end
                if (o_m_axis_tdata[1] !== want.pixel) begin
                    $display("%0t: pixel mismatch: expected %b, actual %b",
                             $time, want.pixel, o_m_axis_tdata[1]);
                    errors++;
                end
                if (o_m_axis_tdata[0] === 1'b1) collisions_seen++;
                if (o_m_axis_tdata[1] === 1'b1) lit_reads++;
            end
        end
    end

    // Empty frame after reset, including out-of-range reads
    task automatic test_reset_readback();
        read_px(0, 0);
        read_px(SFE_MAX_COLS / 2 - 1, SFE_MAX_ROWS / 2 - 1);
        read_px(255, 255);
    endtask

    // Narrow and wide rows, collision build-up, ignored upper bits, dropped pixels
    task automatic test_sprite_rows();
        draw_row(0, 0, 16'h00FF, 1'b0, 1'b0);
        draw_row(0, 0, 16'hFFFF, 1'b1, 1'b1);
        read_px(8, 0);
        draw_row(255, 255, 16'hFF00, 1'b0, 1'b1);
        draw_row(60, 31, 16'hA5A5, 1'b1, 1'b1);
    endtask

    // Wrapping on both edges
    task automatic test_edge_wrap();
        set_edge_mode(REG_WRAP_X, 1'b1);
        set_edge_mode(REG_WRAP_Y, 1'b1);
        draw_row(56, 40, 16'hFFFF, 1'b1, 1'b1);
        read_px(2, 8);
        draw_row(255, 255, 16'h0080, 1'b0, 1'b1);
        read_px(63, 31);
        set_edge_mode(REG_WRAP_X, 1'b0);
        set_edge_mode(REG_WRAP_Y, 1'b0);
    endtask

    // Scrolls in low resolution, halved amounts down to zero
    task automatic test_scrolls();
        frame_op(OP_SCR_DOWN, 15);
        frame_op(OP_SCR_RIGHT, 1);
        frame_op(OP_SCR_RIGHT, 15);
        frame_op(OP_SCR_LEFT, 4);
        read_px(9, 15);
    endtask

    // Hidden columns survive a low-res clear; a switch empties the upper rows
    task automatic test_resolution_and_clear();
        draw_row(60, 2, 16'hF000, 1'b1, 1'b1);
        frame_op(OP_SCR_RIGHT, 15);
        frame_op(OP_CLEAR, 0);
        frame_op(OP_HIGH_RES, 0);
        read_px(68, 2);
        draw_row(112, 63, 16'hFFFF, 1'b1, 1'b1);
        read_px(127, 63);
        read_px(128, 0);
        frame_op(OP_LOW_RES, 0);
        frame_op(OP_HIGH_RES, 0);
        read_px(127, 63);
        frame_op(OP_LOW_RES, 0);
    endtask

    function automatic int pick_coord(input int extent);
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(0, extent - 1);
            2:       return $urandom_range(extent - 16, extent + 8);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Mostly whole sprites with read-backs; some noise, scrolls, clears and switches
    task automatic run_random_phase(input int quota);
        int made, next_mix, kind, n_rows, ox, oy, cols, rows;
        bit wide, drop_last;
        made     = 0;
        next_mix = 0;
        ox       = 0;
        oy       = 0;
        while (made < quota) begin
            if (made >= next_mix) begin
                src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 12;
                sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
                next_mix     = made + 40;
            end
            cols = hires_now ? SFE_MAX_COLS : SFE_MAX_COLS / 2;
            rows = hires_now ? SFE_MAX_ROWS : SFE_MAX_ROWS / 2;
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // one sprite, sometimes over the previous one, sometimes unterminated
                if ($urandom_range(0, 9) >= 4) begin
                    ox = pick_coord(cols);
                    oy = pick_coord(rows);
                end
                n_rows    = $urandom_range(1, 16);
                wide      = $urandom_range(0, 1);
                drop_last = ($urandom_range(0, 9) == 0);
                for (int r = 0; r < n_rows; r++) begin
                    draw_row(ox, (oy + r) & 8'hFF, $urandom_range(0, 16'hFFFF), wide,
                             (r == n_rows - 1) && !drop_last);
                    made++;
                end
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        read_px($urandom_range(0, 255), $urandom_range(0, 255));
                    else
                        read_px((ox + $urandom_range(0, 15)) & 8'hFF,
                                (oy + $urandom_range(0, 15)) & 8'hFF);
                    made++;
                end
            end else begin
                if (kind < 88)
                    send_item(make_item(t_op'($urandom_range(0, 7)), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 16'hFFFF),
                                        $urandom_range(0, 1), $urandom_range(0, 1),
                                        $urandom_range(0, 15)));
                else if (kind < 94)
                    send_item(make_item(t_op'($urandom_range(OP_SCR_DOWN, OP_SCR_LEFT)),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 16'hFFFF), $urandom_range(0, 1),
                                        $urandom_range(0, 1), $urandom_range(0, 15)));
                else if (kind < 96)
                    frame_op(OP_CLEAR, 0);
                else
                    frame_op($urandom_range(0, 1) ? OP_HIGH_RES : OP_LOW_RES, 0);
                made++;
            end
        end
    endtask

    // Random traffic under every edge-mode setting
    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            set_edge_mode(REG_WRAP_X, p[0] ? 1'b0 : 1'b1);
            set_edge_mode(REG_WRAP_Y, p[1] ? 1'b0 : 1'b1);
            run_random_phase(RANDOM_ITEMS / 4);
        end
    endtask

    initial begin
        for (int y = 0; y < SFE_MAX_ROWS; y++) frame_rows[y] = '0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_CLEAR;
        i_s_axis_tlast  = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_readback();
        test_sprite_rows();
        test_edge_wrap();
        test_scrolls();
        test_resolution_and_clear();
        test_random_traffic();
        settle_idle();

        $display("Sent %0d items and checked %0d results in %0d cycles.",
                 items_sent, results_seen, cycle_count);
        $display("Seen %0d collision flags and %0d lit pixel reads over all edge modes.",
                 collisions_seen, lit_reads);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
